FILE: hw/rtl/hgp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hgp_pkg: shared types and constants of the hex grid point pick
// field widths, register indexes, candidate record and defaults
// ----------------------------------------------------------------------------
package hgp_pkg;

  localparam int POS_W      = 24;               // signed Q16.8 coordinate
  localparam int CNT_W      = 11;               // grid_rows / grid_columns
  localparam int PITCH_W    = 20;               // Q12.8 pitch
  localparam int RAD_W      = 20;               // Q12.8 radius
  localparam int HIT_W      = 10;               // reported row / column
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int MAG_W      = 23;               // clamped |difference|
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int LIM_W      = 2 * (RAD_W + 1);
  localparam int PROD_W     = CNT_W + 1 + PITCH_W;
  localparam int DIFF_W     = PROD_W + 2;

  localparam logic [MAG_W-1:0]   DIFF_CLAMP = MAG_W'(1 << 22);
  localparam logic [PITCH_W-1:0] PITCH_RST  = PITCH_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEX_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HPITCH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VPITCH       = 3'd4;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_SEARCH_SPAN = 5;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dsq;
    logic [HIT_W-1:0]  row;
    logic [HIT_W-1:0]  col;
  } hgp_cand_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hgp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hgp_div: pipelined floor division
// signed dividend by unsigned nonzero divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module hgp_div #(
  parameter int DW = 23,
  parameter int VW = 20,
  parameter int SW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [DW:0]   dvd_i,
  input  logic [VW-1:0]        dvs_i,
  input  logic [SW-1:0]        side_i,
  output logic                 out_vld,
  output logic signed [DW:0]   quo_o,
  output logic [SW-1:0]        side_o
);

  logic [VW-1:0] rem_r  [DW];
  logic [DW-1:0] dvd_r  [DW];
  logic [DW-1:0] quo_r  [DW+1];
  logic          neg_r  [DW+1];
  logic [SW-1:0] side_r [DW+1];
  logic [DW:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DW-1:0], in_vld};
    end
  end

  // floor(a/b) for negative a is ~(~a / b)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      dvd_r[0]  <= dvd_i[DW] ? ~dvd_i[DW-1:0] : dvd_i[DW-1:0];
      quo_r[0]  <= '0;
      neg_r[0]  <= dvd_i[DW];
      side_r[0] <= side_i;
    end
  end

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[s], dvd_r[s][DW-1]};
      diff    = trial - {1'b0, dvs_i};
      ge      = trial >= {1'b0, dvs_i};
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    if (s < DW - 1) begin : g_more
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          dvd_r[s+1] <= {dvd_r[s][DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s+1]  <= {quo_r[s][DW-2:0], ge};
        neg_r[s+1]  <= neg_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld = vld_r[DW];
  assign quo_o   = neg_r[DW] ? ~{1'b0, quo_r[DW]} : {1'b0, quo_r[DW]};
  assign side_o  = side_r[DW];

endmodule
`default_nettype wire

FILE: hw/rtl/hgp_cand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hgp_cand: neighborhood candidate distances
// clips rows and columns, forms centers, clamps differences, squares, sums
// ----------------------------------------------------------------------------
module hgp_cand #(
  parameter int SEARCH_SPAN = 5,
  parameter int NC          = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [hgp_pkg::POS_W-1:0]   row_guess,
  input  logic signed [hgp_pkg::POS_W-1:0]   col_guess,
  input  logic signed [hgp_pkg::POS_W-1:0]   pos_x,
  input  logic signed [hgp_pkg::POS_W-1:0]   pos_y,
  input  logic [hgp_pkg::CNT_W-1:0]          rows,
  input  logic [hgp_pkg::CNT_W-1:0]          cols,
  input  logic [hgp_pkg::PITCH_W-1:0]        hpitch,
  input  logic [hgp_pkg::PITCH_W-1:0]        vpitch,
  output logic                               out_vld,
  output hgp_pkg::hgp_cand_t                 cand_o [NC]
);
  import hgp_pkg::*;

  localparam int HALF = SEARCH_SPAN / 2;
  localparam int N    = 2 * HALF + 1;
  localparam int RW   = POS_W + 2;

  function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return (m > DIFF_W'(DIFF_CLAMP)) ? DIFF_CLAMP : m[MAG_W-1:0];
  endfunction

  logic [4:0] vld_r;

  // stage 1: clipped indexes
  logic             row_ok_c  [N];
  logic [CNT_W-1:0] row_idx_c [N];
  logic             col_ok_c  [N];
  logic [CNT_W-1:0] col_idx_c [N];

  logic              row_ok1_r [N];
  logic [CNT_W-1:0]  row_idx1_r[N];
  logic              col_ok1_r [N];
  logic [CNT_W-1:0]  col_idx1_r[N];
  logic [POS_W-1:0]  px1_r, py1_r;

  // stage 2: center products
  logic              row_ok2_r [N];
  logic [CNT_W-1:0]  row_idx2_r[N];
  logic              col_ok2_r [N];
  logic [CNT_W-1:0]  col_idx2_r[N];
  logic [PROD_W-1:0] row_prod2_r[N];
  logic [PROD_W-1:0] col_pe2_r [N];
  logic [PROD_W-1:0] col_po2_r [N];
  logic [POS_W-1:0]  px2_r, py2_r;

  // stage 3: clamped magnitudes
  logic              row_ok3_r [N];
  logic [CNT_W-1:0]  row_idx3_r[N];
  logic              col_ok3_r [N];
  logic [CNT_W-1:0]  col_idx3_r[N];
  logic [MAG_W-1:0]  dy3_r [N];
  logic [MAG_W-1:0]  dxe3_r[N];
  logic [MAG_W-1:0]  dxo3_r[N];

  // stage 4: squares
  logic              row_ok4_r [N];
  logic [CNT_W-1:0]  row_idx4_r[N];
  logic              col_ok4_r [N];
  logic [CNT_W-1:0]  col_idx4_r[N];
  logic [SQ_W-1:0]   sy4_r [N];
  logic [SQ_W-1:0]   sxe4_r[N];
  logic [SQ_W-1:0]   sxo4_r[N];

  hgp_cand_t cand5_r [NC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_idx
    localparam logic signed [RW-1:0] OFF = RW'(i - HALF);
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] c;

    always_comb begin
      r = $signed({{2{row_guess[POS_W-1]}}, row_guess}) + OFF;
      c = $signed({{2{col_guess[POS_W-1]}}, col_guess}) + OFF;
      row_ok_c[i]  = !r[RW-1] && (r < $signed({{(RW-CNT_W){1'b0}}, rows}));
      col_ok_c[i]  = !c[RW-1] && (c < $signed({{(RW-CNT_W){1'b0}}, cols}));
      row_idx_c[i] = r[CNT_W-1:0];
      col_idx_c[i] = c[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= pos_x;
      py1_r <= pos_y;
      px2_r <= px1_r;
      py2_r <= py1_r;
      for (int i = 0; i < N; i++) begin
        row_ok1_r[i]  <= row_ok_c[i];
        row_idx1_r[i] <= row_idx_c[i];
        col_ok1_r[i]  <= col_ok_c[i];
        col_idx1_r[i] <= col_idx_c[i];

        // doubled units: (2k+1)*pitch, or 2k*pitch on even rows
        row_ok2_r[i]   <= row_ok1_r[i];
        row_idx2_r[i]  <= row_idx1_r[i];
        col_ok2_r[i]   <= col_ok1_r[i];
        col_idx2_r[i]  <= col_idx1_r[i];
        row_prod2_r[i] <= PROD_W'({row_idx1_r[i], 1'b1}) * PROD_W'(vpitch);
        col_pe2_r[i]   <= PROD_W'({col_idx1_r[i], 1'b0}) * PROD_W'(hpitch);
        col_po2_r[i]   <= PROD_W'({col_idx1_r[i], 1'b1}) * PROD_W'(hpitch);

        row_ok3_r[i]  <= row_ok2_r[i];
        row_idx3_r[i] <= row_idx2_r[i];
        col_ok3_r[i]  <= col_ok2_r[i];
        col_idx3_r[i] <= col_idx2_r[i];
        dy3_r[i]  <= clamp_mag($signed({{(DIFF_W-POS_W-1){py2_r[POS_W-1]}}, py2_r, 1'b0})
                               - $signed({2'b00, row_prod2_r[i]}));
        dxe3_r[i] <= clamp_mag($signed({{(DIFF_W-POS_W-1){px2_r[POS_W-1]}}, px2_r, 1'b0})
                               - $signed({2'b00, col_pe2_r[i]}));
        dxo3_r[i] <= clamp_mag($signed({{(DIFF_W-POS_W-1){px2_r[POS_W-1]}}, px2_r, 1'b0})
                               - $signed({2'b00, col_po2_r[i]}));

        row_ok4_r[i]  <= row_ok3_r[i];
        row_idx4_r[i] <= row_idx3_r[i];
        col_ok4_r[i]  <= col_ok3_r[i];
        col_idx4_r[i] <= col_idx3_r[i];
        sy4_r[i]  <= SQ_W'(dy3_r[i])  * SQ_W'(dy3_r[i]);
        sxe4_r[i] <= SQ_W'(dxe3_r[i]) * SQ_W'(dxe3_r[i]);
        sxo4_r[i] <= SQ_W'(dxo3_r[i]) * SQ_W'(dxo3_r[i]);
      end

      // scan order: row major, increasing column
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          cand5_r[i*N+j].vld <= row_ok4_r[i] && col_ok4_r[j];
          cand5_r[i*N+j].dsq <= DIST_W'(sy4_r[i]) +
                                DIST_W'(row_idx4_r[i][0] ? sxo4_r[j] : sxe4_r[j]);
          cand5_r[i*N+j].row <= row_idx4_r[i][HIT_W-1:0];
          cand5_r[i*N+j].col <= col_idx4_r[j][HIT_W-1:0];
        end
      end
    end
  end

  assign out_vld = vld_r[4];
  assign cand_o  = cand5_r;

endmodule
`default_nettype wire

FILE: hw/rtl/hgp_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hgp_tree: registered nearest-candidate tree
// keeps the earlier candidate on equal distance, one level per stage
// ----------------------------------------------------------------------------
module hgp_tree #(
  parameter int NC = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  hgp_pkg::hgp_cand_t cand_i [NC],
  output logic               out_vld,
  output hgp_pkg::hgp_cand_t cand_o
);
  import hgp_pkg::*;

  localparam int LEVELS = $clog2(NC);
  localparam int P      = 1 << LEVELS;

  hgp_cand_t        lvl [LEVELS+1][P];
  logic [LEVELS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= LEVELS'({vld_r, in_vld});
    end
  end

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < NC) begin : g_used
      assign lvl[0][i] = cand_i[i];
    end else begin : g_pad
      assign lvl[0][i] = '0;
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < P; i++) begin : g_node
      if (i < (P >> (l + 1))) begin : g_cmp
        logic take_b;
        always_comb begin
          take_b = lvl[l][2*i+1].vld &&
                   (!lvl[l][2*i].vld || (lvl[l][2*i+1].dsq < lvl[l][2*i].dsq));
        end
        always_ff @(posedge clk) begin
          if (en) begin
            lvl[l+1][i] <= take_b ? lvl[l][2*i+1] : lvl[l][2*i];
          end
        end
      end else begin : g_idle
        assign lvl[l+1][i] = '0;
      end
    end
  end

  assign out_vld = vld_r[LEVELS-1];
  assign cand_o  = lvl[LEVELS][0];

endmodule
`default_nettype wire

FILE: hw/rtl/hex_grid_point_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_grid_point_pick: nearest hex center on an odd-row-shifted grid
// config registers, floor dividers, candidate pipeline, nearest tree, output
// ----------------------------------------------------------------------------
// Takes one point per clock while not stalled and returns one result per
// point, in order. The pipeline runs 24 divider stages (an input stage, then
// one quotient bit each for the row and column guess), 5 candidate stages,
// ceil(log2(NC)) tree stages for NC = N*N candidates and an output register.
// A stall on the output freezes the whole pipeline; bubbles are squeezed
// only at the output register. Configuration must be written while no point
// is in flight; the radius limit is registered from the stored radius.
module hex_grid_point_pick #(
  parameter int MAX_ROWS    = hgp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = hgp_pkg::DEF_MAX_COLUMNS,
  parameter int SEARCH_SPAN = hgp_pkg::DEF_SEARCH_SPAN
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hgp_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [hgp_pkg::POS_W-1:0]  in_pos_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [hgp_pkg::HIT_W-1:0]         out_hit_row,
  output logic [hgp_pkg::HIT_W-1:0]         out_hit_column,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hgp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hgp_pkg::*;

  localparam int HALF = SEARCH_SPAN / 2;
  localparam int N    = 2 * HALF + 1;
  localparam int NC   = N * N;
  localparam int DW   = POS_W - 1;

  logic [CNT_W-1:0]   grid_rows_r, grid_columns_r;
  logic [RAD_W-1:0]   hex_radius_r;
  logic [PITCH_W-1:0] hpitch_r, vpitch_r;
  logic [LIM_W-1:0]   rad_lim_r;

  logic [CNT_W-1:0]   rows_eff, cols_eff;
  logic [PITCH_W-1:0] hp_eff, vp_eff;
  logic               en;

  logic                    div_vld, div_vld_y;
  logic signed [DW:0]      col_guess, row_guess;
  logic [POS_W-1:0]        px_d, py_d;
  logic                    cand_vld;
  hgp_cand_t               cand [NC];
  logic                    tree_vld;
  hgp_cand_t               best;
  logic                    hit;

  logic                    out_valid_r, found_r;
  logic [HIT_W-1:0]        row_r, col_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r    <= '0;
      grid_columns_r <= '0;
      hex_radius_r   <= '0;
      hpitch_r       <= PITCH_RST;
      vpitch_r       <= PITCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_ROWS:    grid_rows_r    <= cfg_data[CNT_W-1:0];
        REG_GRID_COLUMNS: grid_columns_r <= cfg_data[CNT_W-1:0];
        REG_HEX_RADIUS:   hex_radius_r   <= cfg_data[RAD_W-1:0];
        REG_HPITCH:       hpitch_r       <= cfg_data[PITCH_W-1:0];
        REG_VPITCH:       vpitch_r       <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // squared doubled radius
  always_ff @(posedge clk) begin
    rad_lim_r <= LIM_W'({hex_radius_r, 1'b0}) * LIM_W'({hex_radius_r, 1'b0});
  end

  always_comb begin
    rows_eff = (int'(grid_rows_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : grid_rows_r;
    cols_eff = (int'(grid_columns_r) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : grid_columns_r;
    hp_eff   = (hpitch_r == '0) ? PITCH_W'(1) : hpitch_r;
    vp_eff   = (vpitch_r == '0) ? PITCH_W'(1) : vpitch_r;
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  hgp_div #(.DW(DW), .VW(PITCH_W), .SW(POS_W)) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .dvd_i  (in_pos_x),
    .dvs_i  (hp_eff),
    .side_i (in_pos_x),
    .out_vld(div_vld),
    .quo_o  (col_guess),
    .side_o (px_d)
  );

  hgp_div #(.DW(DW), .VW(PITCH_W), .SW(POS_W)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .dvd_i  (in_pos_y),
    .dvs_i  (vp_eff),
    .side_i (in_pos_y),
    .out_vld(div_vld_y),
    .quo_o  (row_guess),
    .side_o (py_d)
  );

  hgp_cand #(.SEARCH_SPAN(SEARCH_SPAN), .NC(NC)) u_cand (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld && div_vld_y),
    .row_guess(row_guess),
    .col_guess(col_guess),
    .pos_x    ($signed(px_d)),
    .pos_y    ($signed(py_d)),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .hpitch   (hp_eff),
    .vpitch   (vp_eff),
    .out_vld  (cand_vld),
    .cand_o   (cand)
  );

  hgp_tree #(.NC(NC)) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (cand_vld),
    .cand_i (cand),
    .out_vld(tree_vld),
    .cand_o (best)
  );

  assign hit = best.vld && (best.dsq < DIST_W'(rad_lim_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tree_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found_r <= hit;
      row_r   <= hit ? best.row : '0;
      col_r   <= hit ? best.col : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_hit_row    = row_r;
  assign out_hit_column = col_r;

endmodule
`default_nettype wire
